@@ rtl/mandelbrot_escape_time_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/met_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Field widths, register indexes and reset values, shared types and the
// saturation helper used by the coordinate front end and the iteration engine.
// ----------------------------------------------------------------------------
package met_pkg;

   localparam int PIX_W      = 12;
   localparam int COUNT_W    = 16;
   localparam int WORD_W     = 32;
   localparam int STEP_W     = 31;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int SAT_IN_W   = 66;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_REAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IMAG = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_REAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_IMAG   = 3'd4;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   localparam logic [COUNT_W-1:0] RST_MAX_ITER    = 16'd256;
   localparam word_type           RST_ORIGIN_REAL = -32'sd536870912;
   localparam word_type           RST_ORIGIN_IMAG = -32'sd322122547;
   localparam logic [STEP_W-1:0]  RST_STEP_REAL   = 31'd786432;
   localparam logic [STEP_W-1:0]  RST_STEP_IMAG   = 31'd838861;

   typedef struct packed {
      logic [COUNT_W-1:0] max_iter;
      word_type           origin_real;
      word_type           origin_imag;
      logic [STEP_W-1:0]  step_real;
      logic [STEP_W-1:0]  step_imag;
   } cfg_type;

   // One point c of the complex plane, queued between front end and engine.
   typedef struct packed {
      word_type cr;
      word_type ci;
   } point_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_HOLD
   } engine_state_type;

   // Clamp a wide signed value to the 32-bit signed word range.
   function automatic word_type sat_word(input logic signed [SAT_IN_W-1:0] v);
      word_type r;
      if (v > SAT_IN_W'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < SAT_IN_W'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/met_if.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time channel interfaces
// Valid/ready channels for pixel requests, count responses and register writes.
// ----------------------------------------------------------------------------
interface met_req_if;
   import met_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface met_rsp_if;
   import met_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] iteration_count;
   modport source (output valid, output iteration_count, input ready);
   modport sink (input valid, input iteration_count, output ready);
endinterface

interface met_csr_if;
   import met_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/met_front.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time front end
// Accepts pixel coordinates, scales them by the step registers in one stage
// and adds the origin with saturation on the way into the point queue.
// ----------------------------------------------------------------------------
module met_front #(
   parameter int COORD_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  met_pkg::cfg_type   cfg,
   met_req_if.sink            req_bus,
   output logic               push_valid,
   input  logic               push_ready,
   output met_pkg::point_type push_data
);
   import met_pkg::*;

   localparam int USE_BITS = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
   localparam int SCALE_W  = STEP_W + USE_BITS;

   logic               valid_ff;
   logic               valid_in;
   logic [SCALE_W-1:0] scale_re_ff;
   logic [SCALE_W-1:0] scale_re_in;
   logic [SCALE_W-1:0] scale_im_ff;
   logic [SCALE_W-1:0] scale_im_in;
   logic               advance;

   assign advance       = !valid_ff || push_ready;
   assign req_bus.ready = advance;

   always_comb begin
      valid_in    = advance ? req_bus.valid : valid_ff;
      scale_re_in = SCALE_W'(cfg.step_real) * SCALE_W'(req_bus.pixel_x[USE_BITS-1:0]);
      scale_im_in = SCALE_W'(cfg.step_imag) * SCALE_W'(req_bus.pixel_y[USE_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_bus.valid) begin
         scale_re_ff <= scale_re_in;
         scale_im_ff <= scale_im_in;
      end
   end

   assign push_valid   = valid_ff;
   assign push_data.cr = sat_word(SAT_IN_W'(cfg.origin_real)
                                  + $signed(SAT_IN_W'(scale_re_ff)));
   assign push_data.ci = sat_word(SAT_IN_W'(cfg.origin_imag)
                                  + $signed(SAT_IN_W'(scale_im_ff)));

endmodule

@@ rtl/met_queue.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time point queue
// Short first-in first-out buffer of points between front end and engine.
// ----------------------------------------------------------------------------
module met_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  met_pkg::point_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output met_pkg::point_type pop_data
);
   import met_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   point_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/met_engine.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time iteration engine
// Runs z = z^2 + c for one point at a time, each iteration a multiply state then
// an update state, and keeps the finished count in an output register.
// ----------------------------------------------------------------------------
module met_engine #(
   parameter int FRAC_BITS = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  met_pkg::cfg_type   cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  met_pkg::point_type pop_data,
   met_rsp_if.source          rsp_bus
);
   import met_pkg::*;

   `include "mandelbrot_escape_time_unit_macros.svh"

   localparam int MAG_W = PROD_W + 1;
   localparam logic [MAG_W-1:0] ESC_BOUND = MAG_W'(1) << (2 * FRAC_BITS + 2);

   engine_state_type   state_ff;
   engine_state_type   state_in;
   word_type           cr_ff;
   word_type           cr_in;
   word_type           ci_ff;
   word_type           ci_in;
   word_type           zr_ff;
   word_type           zr_in;
   word_type           zi_ff;
   word_type           zi_in;
   prod_type           rr_ff;
   prod_type           rr_in;
   prod_type           ii_ff;
   prod_type           ii_in;
   prod_type           ri_ff;
   prod_type           ri_in;
   logic [COUNT_W-1:0] n_ff;
   logic [COUNT_W-1:0] n_in;
   logic               pending_ff;
   logic               pending_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;

   logic [MAG_W-1:0]          mag;
   logic                      escaped;
   logic [COUNT_W-1:0]        n_step;
   logic signed [SAT_IN_W-1:0] diff;
   word_type                  nr;
   word_type                  ni;
   logic                      slot_free;

   assign pop_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // The squares of the current z double as the escape test of the last update.
   assign mag     = MAG_W'($unsigned(rr_ff)) + MAG_W'($unsigned(ii_ff));
   assign escaped = pending_ff && (mag >= ESC_BOUND);
   assign n_step  = pending_ff ? n_ff + COUNT_W'(1) : n_ff;
   assign diff    = SAT_IN_W'(rr_ff) - SAT_IN_W'(ii_ff);
   assign nr      = sat_word((diff >>> FRAC_BITS) + SAT_IN_W'(cr_ff));
   assign ni      = sat_word((SAT_IN_W'(ri_ff) >>> (FRAC_BITS - 1)) + SAT_IN_W'(ci_ff));

   always_comb begin
      state_in     = state_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      n_in         = n_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cr_in      = pop_data.cr;
               ci_in      = pop_data.ci;
               zr_in      = '0;
               zi_in      = '0;
               n_in       = '0;
               pending_in = 1'b0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            rr_in    = PROD_W'(zr_ff) * PROD_W'(zr_ff);
            ii_in    = PROD_W'(zi_ff) * PROD_W'(zi_ff);
            ri_in    = PROD_W'(zr_ff) * PROD_W'(zi_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (escaped) begin
               state_in = ST_HOLD;
            end else if (n_step == cfg.max_iter) begin
               n_in     = n_step;
               state_in = ST_HOLD;
            end else begin
               zr_in      = nr;
               zi_in      = ni;
               n_in       = n_step;
               pending_in = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = n_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      rr_ff        <= rr_in;
      ii_ff        <= ii_in;
      ri_ff        <= ri_in;
      n_ff         <= n_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.iteration_count = rsp_count_ff;

   `MET_ASSERT_NEXT(a_hold_delivers, clock, reset, (state_ff == ST_HOLD) && slot_free, rsp_valid_ff && (state_ff == ST_IDLE), "finished count was not moved to the output register")
   `MET_ASSERT_SAME(a_add_after_mul, clock, reset, state_ff == ST_ADD, $past(state_ff) == ST_MUL, "update step entered without fresh products")
   `MET_ASSERT_NEXT(a_start_clean, clock, reset, (state_ff == ST_IDLE) && pop_valid, (n_ff == '0) && !pending_ff && (state_ff == ST_MUL), "new point did not start from a cleared count")

endmodule

@@ rtl/mandelbrot_escape_time_unit.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Maps a pixel to a point c of the complex plane and counts the iterations of
// z = z^2 + c that stay inside |z|^2 < 4, in signed fixed point.
// ----------------------------------------------------------------------------
//   Port     Role    Payload
//   req_bus  sink    pixel_x, pixel_y
//   rsp_bus  source  iteration_count
//   csr_bus  sink    index, data (always ready)
//
// The engine runs each iteration as a multiply state, then an update and escape
// test state; this loop sets the rate at which pixels complete.
// The front end and a two-entry point queue keep accepting pixels, until the
// queue fills, while the engine is busy and while a result waits on rsp_bus.
// Synchronous reset clears the handshake state and loads the register defaults.
module mandelbrot_escape_time_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 28
) (
   input logic       clock,
   input logic       reset,
   met_req_if.sink   req_bus,
   met_rsp_if.source rsp_bus,
   met_csr_if.sink   csr_bus
);
   import met_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      push_valid;
   logic      push_ready;
   point_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   point_type pop_data;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MAX_ITER:    cfg_in.max_iter    = csr_bus.data[COUNT_W-1:0];
            CSR_ORIGIN_REAL: cfg_in.origin_real = csr_bus.data[WORD_W-1:0];
            CSR_ORIGIN_IMAG: cfg_in.origin_imag = csr_bus.data[WORD_W-1:0];
            CSR_STEP_REAL:   cfg_in.step_real   = csr_bus.data[STEP_W-1:0];
            CSR_STEP_IMAG:   cfg_in.step_imag   = csr_bus.data[STEP_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iter    <= RST_MAX_ITER;
         cfg_ff.origin_real <= RST_ORIGIN_REAL;
         cfg_ff.origin_imag <= RST_ORIGIN_IMAG;
         cfg_ff.step_real   <= RST_STEP_REAL;
         cfg_ff.step_imag   <= RST_STEP_IMAG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   met_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   met_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   met_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ bench/mandelbrot_escape_time_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit testbench
// Streams pixel coordinates into the unit under several register settings,
// predicts each iteration count in fixed point and checks every response in
// order. Both channels idle in random bursts, and the final phase runs without
// idling.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit_test;
   import met_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 28;
   localparam longint COORD_MASK = (longint'(1) << COORD_BITS) - 1;
   localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;

   met_req_if req_bus ();
   met_rsp_if rsp_bus ();
   met_csr_if csr_bus ();

   mandelbrot_escape_time_unit #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   cfg_type            shadow_cfg;
   pixel_type          pixel_queue[$];
   logic [COUNT_W-1:0] expected_counts[$];
   int                 failures = 0;
   int                 idle_odds = 3;
   int                 send_gap;
   int                 stall_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clamp_word(input longint v);
      if (v > longint'(WORD_MAX)) begin
         return longint'(WORD_MAX);
      end else if (v < longint'(WORD_MIN)) begin
         return longint'(WORD_MIN);
      end
      return v;
   endfunction

   // Iterations of z = z^2 + c that stay inside |z|^2 < 4 for one pixel.
   function automatic logic [COUNT_W-1:0] escape_count(input logic [PIX_W-1:0] px,
                                                       input logic [PIX_W-1:0] py);
      longint          cr, ci, zr, zi, nr, ni, rr, ii, ri;
      longint unsigned mag;
      int unsigned     n;
      cr = clamp_word(longint'(shadow_cfg.origin_real)
                      + longint'(shadow_cfg.step_real) * (longint'(px) & COORD_MASK));
      ci = clamp_word(longint'(shadow_cfg.origin_imag)
                      + longint'(shadow_cfg.step_imag) * (longint'(py) & COORD_MASK));
      zr = 0;
      zi = 0;
      n  = 0;
      while (n < shadow_cfg.max_iter) begin
         rr  = zr * zr;
         ii  = zi * zi;
         ri  = zr * zi;
         nr  = clamp_word(((rr - ii) >>> FRAC_BITS) + cr);
         ni  = clamp_word((ri >>> (FRAC_BITS - 1)) + ci);
         mag = unsigned'(nr * nr) + unsigned'(ni * ni);
         zr  = nr;
         zi  = ni;
         if (mag >= ESCAPE_BOUND) break;
         n++;
      end
      return n[COUNT_W-1:0];
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_MAX_ITER: begin
            shadow_cfg.max_iter = value[COUNT_W-1:0];
         end
         CSR_ORIGIN_REAL: begin
            shadow_cfg.origin_real = value[WORD_W-1:0];
         end
         CSR_ORIGIN_IMAG: begin
            shadow_cfg.origin_imag = value[WORD_W-1:0];
         end
         CSR_STEP_REAL: begin
            shadow_cfg.step_real = value[STEP_W-1:0];
         end
         CSR_STEP_IMAG: begin
            shadow_cfg.step_imag = value[STEP_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      apply_register(idx, value);
   endtask

   task automatic configure(input logic [31:0] limit, input logic [31:0] ore,
                            input logic [31:0] oim, input logic [31:0] sre,
                            input logic [31:0] sim);
      write_register(CSR_MAX_ITER, limit);
      write_register(CSR_ORIGIN_REAL, ore);
      write_register(CSR_ORIGIN_IMAG, oim);
      write_register(CSR_STEP_REAL, sre);
      write_register(CSR_STEP_IMAG, sim);
   endtask

   task automatic add_pixel(input int x, input int y);
      @(negedge clock);
      pixel_queue.push_back('{x: x[PIX_W-1:0], y: y[PIX_W-1:0]});
   endtask

   // Returns once every queued pixel has been answered and the unit has settled.
   task automatic wait_for_drain();
      while (pixel_queue.size() != 0 || req_bus.valid || expected_counts.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_pixels
      pixel_type item;
      logic      busy;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         busy = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_counts.push_back(escape_count(req_bus.pixel_x, req_bus.pixel_y));
            busy = 1'b0;
         end
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
               item = pixel_queue.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.pixel_x <= item.x;
               req_bus.pixel_y <= item.y;
               if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
                  send_gap = $urandom_range(1, 19);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_counts
      logic [COUNT_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_counts.size() == 0) begin
            $error("iteration_count: expected none, actual %0d", rsp_bus.iteration_count);
            failures++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_bus.iteration_count !== want) begin
               $error("iteration_count: expected %0d, actual %0d", want,
                      rsp_bus.iteration_count);
               failures++;
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [31:0] limit, ore, oim, sre, sim;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.pixel_x = '0;
      req_bus.pixel_y = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      shadow_cfg = '{max_iter: RST_MAX_ITER, origin_real: RST_ORIGIN_REAL,
                     origin_imag: RST_ORIGIN_IMAG, step_real: RST_STEP_REAL,
                     step_imag: RST_STEP_IMAG};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Default view: corners, edges, points inside the set and alternating bits.
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(0, 4095);
      add_pixel(4095, 0);
      add_pixel(2048, 0);
      add_pixel(683, 384);
      add_pixel(512, 384);
      add_pixel(1, 1);
      add_pixel(12'hAAA, 12'h555);
      add_pixel(12'h555, 12'hAAA);
      wait_for_drain();

      // A zero limit runs no iteration; the upper data bits must be dropped.
      configure(32'hFFFF_0000, RST_ORIGIN_REAL, RST_ORIGIN_IMAG, RST_STEP_REAL, RST_STEP_IMAG);
      add_pixel(0, 0);
      add_pixel(683, 384);
      wait_for_drain();

      // Writes to unassigned indexes must leave every register alone.
      for (int k = 1; k <= 3; k++) begin
         write_register(CSR_IDX_W'(CSR_STEP_IMAG + k), $urandom());
      end
      add_pixel(4095, 4095);
      wait_for_drain();

      // c = -2 lands exactly on the escape circle; c = 0.25 is the cusp.
      configure(32'h0001_0100, 32'hE000_0000, 32'h0, 32'h0, 32'h0);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      wait_for_drain();
      write_register(CSR_ORIGIN_REAL, 32'h0400_0000);
      write_register(CSR_MAX_ITER, 32'd200);
      add_pixel(17, 99);
      wait_for_drain();

      // Saturated points at both ends of the word range.
      configure(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(1, 0);
      wait_for_drain();
      configure(32'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(4095, 1);
      wait_for_drain();

      // Largest limit: one point that never escapes, one that escapes at once.
      configure(32'h0000_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
      add_pixel(1234, 321);
      wait_for_drain();
      write_register(CSR_ORIGIN_REAL, 32'h2000_0000);
      add_pixel(0, 0);
      wait_for_drain();

      for (int phase = 0; phase < 8; phase++) begin
         idle_odds = (phase == 7) ? 0 : $urandom_range(0, 6);
         limit = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 48);
         limit = limit | ($urandom() & 32'hFFFF_0000);
         if ($urandom_range(0, 3) == 0) begin
            ore = $urandom();
            oim = $urandom();
            sre = $urandom();
            sim = $urandom();
         end else begin
            // Windows around the set, spanning up to about three units across.
            ore = 32'(int'($urandom_range(0, 400_000_000)) - 603_979_776);
            oim = 32'(int'($urandom_range(0, 400_000_000)) - 350_000_000);
            sre = $urandom_range(0, 200_000) | ($urandom() & 32'h8000_0000);
            sim = $urandom_range(0, 200_000) | ($urandom() & 32'h8000_0000);
         end
         configure(limit, ore, oim, sre, sim);
         for (int k = 0; k < 70; k++) begin
            add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
         end
         wait_for_drain();
      end

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
